// ===== rtl/cspt_pkg.sv =====
// shared types and constants for the correlation stability point core
`default_nettype none

package cspt_pkg;

  localparam int SAMPLE_W   = 16;  // width of one Q8.8 sample
  localparam int CORR_W     = 16;  // width of a Q1.15 corridor limit
  localparam int SIZE_W     = 11;  // width of min_size and stable_size
  localparam int CFG_IDX_W  = 2;
  localparam int CSQ_W      = 31;  // squared limit magnitude, up to 2^30
  localparam int FRAC_SHIFT = 30;  // 2^30 scale of the squared Q1.15 limit

  localparam logic signed [CORR_W-1:0] LOWER_RESET = 16'sd13107;
  localparam logic signed [CORR_W-1:0] UPPER_RESET = 16'sd19661;
  localparam logic [SIZE_W-1:0]        MIN_RESET   = 11'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_MIN   = 2'd2
  } cfg_idx_t;

  // outcome of one correlation test
  typedef enum logic [1:0] {
    CLS_FLAT = 2'd0,
    CLS_IN   = 2'd1,
    CLS_OUT  = 2'd2
  } cls_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       last_pair;
  } in_t;

  typedef struct packed {
    logic [SIZE_W-1:0] stable_size;
    logic              never_stable;
    logic              overflowed;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/cspt_mul.sv =====
// shift-and-add multiplier, one multiplier bit per cycle
`default_nettype none

module cspt_mul #(
  parameter int PW = 139,
  parameter int BW = 54
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [PW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic               done,
  output logic [PW-1:0]      p
);

  logic          busy_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] a_r;
  logic [BW-1:0] b_r;

  // finished once no multiplier bits remain
  assign done = busy_r && (b_r == '0);
  assign p    = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[PW-2:0], 1'b0};
      b_r <= {1'b0, b_r[BW-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/correlation_stability_point_core.sv =====
// top level of the correlation stability point core
`default_nettype none

// Collects sample pairs (x, y) one transfer at a time, storing them in an
// internal memory of MAX_SAMPLES entries and keeping exact running sums of
// x, y, xy, x^2 and y^2. A pair is taken while idle and then summed in the
// states S_LD_XY, S_LD_XX and S_LD_YY by a small 16x16 multiplier.
// The pair flagged last_pair starts the evaluation: the correlation of the
// whole sample is tested against [lower_corr, upper_corr] with exact integer
// sign-and-square compares. Outside gives never_stable; otherwise pairs are
// removed from the end while the correlation stays inside and the count is
// above min_size, and the count reached is reported. Every test runs its
// products through one shared shift-and-add multiplier that retires one
// multiplier bit per cycle and stops at the highest set bit. Each removed
// pair adds a memory read (S_RD, S_RD_CAP), a sum update (S_RM_XY, S_RM_XX,
// S_RM_YY) and one test. Pairs arriving when the store is full are dropped
// and reported through overflowed. in_stall is high for the whole of an
// item's work; a result waiting on out_stall does not block loading the
// next pair.
module correlation_stability_point_core #(
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cspt_pkg::in_t                       in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cspt_pkg::out_t                           out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cspt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cspt_pkg::CORR_W-1:0]         cfg_data
);

  localparam int CW    = $clog2(MAX_SAMPLES + 1);           // pair count
  localparam int AW    = $clog2(MAX_SAMPLES);               // store address
  localparam int SXW   = cspt_pkg::SAMPLE_W + CW;           // sum of x
  localparam int SXYW  = 2 * cspt_pkg::SAMPLE_W - 1 + CW;   // sum of xy
  localparam int SXXW  = 2 * cspt_pkg::SAMPLE_W - 2 + CW;   // sum of x^2
  localparam int MAGW  = 2 * SXW;                           // moment magnitudes
  localparam int PW    = cspt_pkg::CSQ_W + 2 * MAGW;        // widest product
  localparam int CMPW  = (CW > cspt_pkg::SIZE_W) ? CW : cspt_pkg::SIZE_W;
  localparam int PAIRW = 2 * cspt_pkg::SAMPLE_W;

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_LD_XY    = 24'h000002,
    S_LD_XX    = 24'h000004,
    S_LD_YY    = 24'h000008,
    S_CL_START = 24'h000010,
    S_W_NSXY   = 24'h000020,
    S_W_SXSY   = 24'h000040,
    S_W_NSXX   = 24'h000080,
    S_W_SXSX   = 24'h000100,
    S_W_NSYY   = 24'h000200,
    S_W_SYSY   = 24'h000400,
    S_CHK_VAR  = 24'h000800,
    S_W_NSQ    = 24'h001000,
    S_CHK_SIDE = 24'h002000,
    S_W_CSQ    = 24'h004000,
    S_W_CDX    = 24'h008000,
    S_W_CDXDY  = 24'h010000,
    S_DECIDE   = 24'h020000,
    S_RD       = 24'h040000,
    S_RD_CAP   = 24'h080000,
    S_RM_XY    = 24'h100000,
    S_RM_XX    = 24'h200000,
    S_RM_YY    = 24'h400000,
    S_RESULT   = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  // sample state
  logic [CW-1:0]                         pair_count_r;
  logic signed [SXW-1:0]                 sum_x_r, sum_y_r;
  logic signed [SXYW-1:0]                sum_xy_r;
  logic [SXXW-1:0]                       sum_xx_r, sum_yy_r;
  logic                                  ovf_r;
  logic [PAIRW-1:0]                      mem [MAX_SAMPLES];
  logic [PAIRW-1:0]                      mem_rd_r;

  // configuration
  logic signed [cspt_pkg::CORR_W-1:0]    lower_r, upper_r;
  logic [cspt_pkg::SIZE_W-1:0]           min_r;

  // evaluation working registers
  logic signed [cspt_pkg::SAMPLE_W-1:0]  px_r, py_r;
  logic                                  last_r, first_r, side_r, never_r;
  cspt_pkg::cls_t                        cls_r;
  logic signed [MAGW:0]                  t_a_r, dx_r, dy_r;
  logic signed [MAGW+1:0]                num_r;
  logic [PW-1:0]                         s_r;

  logic                                  out_valid_r;
  cspt_pkg::out_t                        out_data_r;

  // shared multiplier hookup
  logic                                  mul_start, mul_done;
  logic [PW-1:0]                         mul_a, mul_p;
  logic [MAGW-1:0]                       mul_b;

  // small pair multiplier
  logic signed [cspt_pkg::SAMPLE_W-1:0]  small_a, small_b;
  logic signed [PAIRW-1:0]               small_prod;

  // magnitudes and flags
  logic [SXW-1:0]                        sx_mag, sy_mag;
  logic [SXYW-1:0]                       sxy_mag;
  logic [MAGW-1:0]                       num_mag, dx_mag, dy_mag;
  logic signed [MAGW+1:0]                num_abs;
  logic signed [MAGW:0]                  pm;
  logic                                  sxsy_neg, flat, num_neg, num_zero;
  logic                                  eff_nonneg, lim_le0, lim_ge0;
  logic                                  sc_false, sc_true, below, walk_more;
  logic signed [cspt_pkg::CORR_W-1:0]    lim;
  logic [cspt_pkg::CORR_W-1:0]           lmag;
  logic                                  in_acc, out_fire, res_fire, has_room;
  logic [CW-1:0]                         rd_count;

  cspt_mul #(
    .PW (PW),
    .BW (MAGW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign res_fire  = (state_r == S_RESULT) && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;
  assign has_room  = pair_count_r < CW'(MAX_SAMPLES);
  assign rd_count  = pair_count_r - CW'(1);

  // pair products: xy, then xx, then yy
  assign small_a    = (state_r == S_LD_YY || state_r == S_RM_YY) ? py_r : px_r;
  assign small_b    = (state_r == S_LD_XX || state_r == S_RM_XX) ? px_r : py_r;
  assign small_prod = small_a * small_b;

  assign sx_mag   = sum_x_r[SXW-1]   ? SXW'(-sum_x_r)   : SXW'(sum_x_r);
  assign sy_mag   = sum_y_r[SXW-1]   ? SXW'(-sum_y_r)   : SXW'(sum_y_r);
  assign sxy_mag  = sum_xy_r[SXYW-1] ? SXYW'(-sum_xy_r) : SXYW'(sum_xy_r);
  assign sxsy_neg = sum_x_r[SXW-1] ^ sum_y_r[SXW-1];
  assign pm       = $signed({1'b0, mul_p[MAGW-1:0]});

  assign num_neg  = num_r[MAGW+1];
  assign num_zero = (num_r == '0);
  assign num_abs  = num_neg ? -num_r : num_r;
  assign num_mag  = num_abs[MAGW-1:0];
  assign dx_mag   = dx_r[MAGW-1:0];
  assign dy_mag   = dy_r[MAGW-1:0];
  // zero or negative variance on either side
  assign flat     = dx_r[MAGW] || (dx_r == '0) || dy_r[MAGW] || (dy_r == '0);

  // lower side tests num against lower, upper side tests -num against -upper
  assign lim        = side_r ? upper_r : lower_r;
  assign lmag       = lim[cspt_pkg::CORR_W-1] ? cspt_pkg::CORR_W'(-lim)
                                              : cspt_pkg::CORR_W'(lim);
  assign eff_nonneg = side_r ? (num_neg || num_zero) : !num_neg;
  assign lim_le0    = side_r ? !upper_r[cspt_pkg::CORR_W-1]
                             : (lower_r[cspt_pkg::CORR_W-1] || (lower_r == '0));
  assign lim_ge0    = side_r ? (upper_r[cspt_pkg::CORR_W-1] || (upper_r == '0))
                             : !lower_r[cspt_pkg::CORR_W-1];
  assign sc_false   = eff_nonneg && lim_le0;
  assign sc_true    = !eff_nonneg && lim_ge0;
  // s holds num^2 * 2^30, mul_p holds lim^2 * dx * dy
  assign below      = eff_nonneg ? (s_r < mul_p) : (s_r > mul_p);
  assign walk_more  = (CMPW'(pair_count_r) > CMPW'(min_r)) && (pair_count_r != '0);

  // sequencer and multiplier launches
  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (has_room) begin
            state_nxt = S_LD_XY;
          end else if (in_data.last_pair) begin
            state_nxt = S_CL_START;
          end
        end
      end
      S_LD_XY: state_nxt = S_LD_XX;
      S_LD_XX: state_nxt = S_LD_YY;
      S_LD_YY: state_nxt = last_r ? S_CL_START : S_IDLE;
      S_CL_START: begin
        mul_start = 1'b1;
        mul_a     = PW'(sxy_mag);
        mul_b     = MAGW'(pair_count_r);
        state_nxt = S_W_NSXY;
      end
      S_W_NSXY: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = PW'(sx_mag);
          mul_b     = MAGW'(sy_mag);
          state_nxt = S_W_SXSY;
        end
      end
      S_W_SXSY: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = PW'(sum_xx_r);
          mul_b     = MAGW'(pair_count_r);
          state_nxt = S_W_NSXX;
        end
      end
      S_W_NSXX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = PW'(sx_mag);
          mul_b     = MAGW'(sx_mag);
          state_nxt = S_W_SXSX;
        end
      end
      S_W_SXSX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = PW'(sum_yy_r);
          mul_b     = MAGW'(pair_count_r);
          state_nxt = S_W_NSYY;
        end
      end
      S_W_NSYY: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = PW'(sy_mag);
          mul_b     = MAGW'(sy_mag);
          state_nxt = S_W_SYSY;
        end
      end
      S_W_SYSY: begin
        if (mul_done) begin
          state_nxt = S_CHK_VAR;
        end
      end
      S_CHK_VAR: begin
        if (flat) begin
          state_nxt = S_DECIDE;
        end else begin
          mul_start = 1'b1;
          mul_a     = PW'(num_mag);
          mul_b     = num_mag;
          state_nxt = S_W_NSQ;
        end
      end
      S_W_NSQ: begin
        if (mul_done) begin
          state_nxt = S_CHK_SIDE;
        end
      end
      S_CHK_SIDE: begin
        if (sc_false) begin
          state_nxt = side_r ? S_DECIDE : S_CHK_SIDE;
        end else if (sc_true) begin
          state_nxt = S_DECIDE;
        end else begin
          mul_start = 1'b1;
          mul_a     = PW'(lmag);
          mul_b     = MAGW'(lmag);
          state_nxt = S_W_CSQ;
        end
      end
      S_W_CSQ: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = PW'(dx_mag);
          mul_b     = MAGW'(mul_p[cspt_pkg::CSQ_W-1:0]);
          state_nxt = S_W_CDX;
        end
      end
      S_W_CDX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = mul_p;
          mul_b     = dy_mag;
          state_nxt = S_W_CDXDY;
        end
      end
      S_W_CDXDY: begin
        if (mul_done) begin
          if (below || side_r) begin
            state_nxt = S_DECIDE;
          end else begin
            state_nxt = S_CHK_SIDE;
          end
        end
      end
      S_DECIDE: begin
        if (!(first_r && cls_r == cspt_pkg::CLS_OUT) && cls_r == cspt_pkg::CLS_IN
            && walk_more) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_RD:     state_nxt = S_RD_CAP;
      S_RD_CAP: state_nxt = S_RM_XY;
      S_RM_XY:  state_nxt = S_RM_XX;
      S_RM_XX:  state_nxt = S_RM_YY;
      S_RM_YY:  state_nxt = S_CL_START;
      S_RESULT: begin
        if (res_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // pair store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (in_acc && has_room) begin
      mem[pair_count_r[AW-1:0]] <= {in_data.x_sample, in_data.y_sample};
    end
    if (state_r == S_RD) begin
      mem_rd_r <= mem[rd_count[AW-1:0]];
    end
  end

  // control state, sums and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pair_count_r <= '0;
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_xy_r     <= '0;
      sum_xx_r     <= '0;
      sum_yy_r     <= '0;
      ovf_r        <= 1'b0;
      lower_r      <= cspt_pkg::LOWER_RESET;
      upper_r      <= cspt_pkg::UPPER_RESET;
      min_r        <= cspt_pkg::MIN_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cspt_pkg::cfg_idx_t'(cfg_index))
          cspt_pkg::CFG_LOWER: lower_r <= $signed(cfg_data);
          cspt_pkg::CFG_UPPER: upper_r <= $signed(cfg_data);
          cspt_pkg::CFG_MIN:   min_r   <= cfg_data[cspt_pkg::SIZE_W-1:0];
          default: ;
        endcase
      end

      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc && !has_room) begin
            ovf_r <= 1'b1;
          end
        end
        S_LD_XY: begin
          sum_x_r  <= sum_x_r + SXW'(px_r);
          sum_y_r  <= sum_y_r + SXW'(py_r);
          sum_xy_r <= sum_xy_r + SXYW'(small_prod);
        end
        S_LD_XX: sum_xx_r <= sum_xx_r + SXXW'(small_prod[PAIRW-2:0]);
        S_LD_YY: begin
          sum_yy_r     <= sum_yy_r + SXXW'(small_prod[PAIRW-2:0]);
          pair_count_r <= pair_count_r + CW'(1);
        end
        S_RM_XY: begin
          sum_x_r  <= sum_x_r - SXW'(px_r);
          sum_y_r  <= sum_y_r - SXW'(py_r);
          sum_xy_r <= sum_xy_r - SXYW'(small_prod);
        end
        S_RM_XX: sum_xx_r <= sum_xx_r - SXXW'(small_prod[PAIRW-2:0]);
        S_RM_YY: begin
          sum_yy_r     <= sum_yy_r - SXXW'(small_prod[PAIRW-2:0]);
          pair_count_r <= rd_count;
        end
        S_RESULT: begin
          if (res_fire) begin
            // sample done, start the next one empty
            pair_count_r <= '0;
            sum_x_r      <= '0;
            sum_y_r      <= '0;
            sum_xy_r     <= '0;
            sum_xx_r     <= '0;
            sum_yy_r     <= '0;
            ovf_r        <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // evaluation payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          px_r    <= in_data.x_sample;
          py_r    <= in_data.y_sample;
          last_r  <= in_data.last_pair;
          first_r <= 1'b1;
        end
      end
      S_W_NSXY: begin
        if (mul_done) begin
          t_a_r <= sum_xy_r[SXYW-1] ? -pm : pm;
        end
      end
      S_W_SXSY: begin
        if (mul_done) begin
          num_r <= (MAGW+2)'(t_a_r) - (MAGW+2)'(sxsy_neg ? -pm : pm);
        end
      end
      S_W_NSXX: if (mul_done) t_a_r <= pm;
      S_W_SXSX: if (mul_done) dx_r <= t_a_r - pm;
      S_W_NSYY: if (mul_done) t_a_r <= pm;
      S_W_SYSY: if (mul_done) dy_r <= t_a_r - pm;
      S_CHK_VAR: begin
        if (flat) begin
          cls_r <= cspt_pkg::CLS_FLAT;
        end
      end
      S_W_NSQ: begin
        if (mul_done) begin
          s_r    <= mul_p << cspt_pkg::FRAC_SHIFT;
          side_r <= 1'b0;
        end
      end
      S_CHK_SIDE: begin
        if (sc_false) begin
          if (side_r) begin
            cls_r <= cspt_pkg::CLS_IN;
          end else begin
            side_r <= 1'b1;
          end
        end else if (sc_true) begin
          cls_r <= cspt_pkg::CLS_OUT;
        end
      end
      S_W_CDXDY: begin
        if (mul_done) begin
          if (below) begin
            cls_r <= cspt_pkg::CLS_OUT;
          end else if (side_r) begin
            cls_r <= cspt_pkg::CLS_IN;
          end else begin
            side_r <= 1'b1;
          end
        end
      end
      S_DECIDE: never_r <= first_r && (cls_r == cspt_pkg::CLS_OUT);
      S_RD:     first_r <= 1'b0;
      S_RD_CAP: begin
        px_r <= $signed(mem_rd_r[PAIRW-1:cspt_pkg::SAMPLE_W]);
        py_r <= $signed(mem_rd_r[cspt_pkg::SAMPLE_W-1:0]);
      end
      S_RESULT: begin
        if (res_fire) begin
          out_data_r.stable_size  <= never_r ? '0 : cspt_pkg::SIZE_W'(pair_count_r);
          out_data_r.never_stable <= never_r;
          out_data_r.overflowed   <= ovf_r;
        end
      end
      default: ;
    endcase
  end

  // checks on the sequencer and sample state
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pair_count_r <= CW'(MAX_SAMPLES))
    else $error("pair count above store capacity");

  a_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.never_stable |-> out_data_r.stable_size == '0)
    else $error("never_stable result carries a size");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> pair_count_r == '0 && !ovf_r && sum_x_r == '0)
    else $error("sample state not cleared after result");

  a_walk_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |-> pair_count_r != '0 && !first_r || pair_count_r != '0)
    else $error("walk reads an empty store");

endmodule

`default_nettype wire

// ===== dv/tb_correlation_stability_point_core.sv =====
// testbench for the correlation stability point core
`timescale 1ns / 1ps

module tb_correlation_stability_point_core;

  localparam int MAX_SAMPLES = 1024;
  localparam int STALL_LIMIT = 200000;  // idle cycles before the watchdog fires
  localparam int TAIL_CYCLES = 400;     // settle time after the last expected result is drained

  typedef logic signed [255:0] wide_t;

  // scoreboard: predicts the stability point of each sample and checks results
  class stability_board;
    int signed lower_lim, upper_lim;
    int unsigned floor_size;
    longint xs[MAX_SAMPLES], ys[MAX_SAMPLES];
    int unsigned count;
    longint sx, sy, sxy, sxx, syy;
    bit dropped;
    cspt_pkg::out_t expected_q[$];
    int errors, results, never_cnt, ovf_cnt;

    function new();
      lower_lim = cspt_pkg::LOWER_RESET;
      upper_lim = cspt_pkg::UPPER_RESET;
      floor_size = cspt_pkg::MIN_RESET;
      clear();
    endfunction

    function void clear();
      count = 0;
      sx = 0; sy = 0; sxy = 0; sxx = 0; syy = 0;
      dropped = 0;
    endfunction

    function void set_reg(cspt_pkg::cfg_idx_t idx, logic [15:0] val);
      case (idx)
        cspt_pkg::CFG_LOWER: lower_lim = $signed(val);
        cspt_pkg::CFG_UPPER: upper_lim = $signed(val);
        cspt_pkg::CFG_MIN:   floor_size = val[cspt_pkg::SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // exact test of num / sqrt(dx*dy) < lim / 2^15 for positive dx, dy
    function bit below(longint num, longint lim, longint dx, longint dy);
      wide_t mag, lmag, lhs, rhs;
      if (num >= 0 && lim <= 0) return 0;
      if (num < 0 && lim >= 0) return 1;
      mag = (num < 0) ? -wide_t'(num) : wide_t'(num);
      lmag = (lim < 0) ? -wide_t'(lim) : wide_t'(lim);
      lhs = (mag * mag) <<< cspt_pkg::FRAC_SHIFT;
      rhs = lmag * lmag * wide_t'(dx) * wide_t'(dy);
      return (num >= 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function cspt_pkg::cls_t classify(longint n, longint ax, longint ay, longint axy,
                                      longint axx, longint ayy);
      longint num, dx, dy;
      num = n * axy - ax * ay;
      dx = n * axx - ax * ax;
      dy = n * ayy - ay * ay;
      if (dx <= 0 || dy <= 0) return cspt_pkg::CLS_FLAT;
      if (below(num, lower_lim, dx, dy)) return cspt_pkg::CLS_OUT;
      if (below(-num, -longint'(upper_lim), dx, dy)) return cspt_pkg::CLS_OUT;
      return cspt_pkg::CLS_IN;
    endfunction

    function void note_pair(cspt_pkg::in_t d);
      longint x, y, n, ax, ay, axy, axx, ayy;
      cspt_pkg::cls_t c;
      cspt_pkg::out_t r;
      x = d.x_sample;
      y = d.y_sample;
      if (count < MAX_SAMPLES) begin
        xs[count] = x; ys[count] = y;
        count++;
        sx += x; sy += y; sxy += x * y; sxx += x * x; syy += y * y;
      end else begin
        dropped = 1;
      end
      if (!d.last_pair) return;
      n = count; ax = sx; ay = sy; axy = sxy; axx = sxx; ayy = syy;
      c = classify(n, ax, ay, axy, axx, ayy);
      r = '0;
      if (c == cspt_pkg::CLS_OUT) begin
        r.never_stable = 1;
      end else begin
        // backward walk from the end of the sample
        while (c == cspt_pkg::CLS_IN && n > floor_size && n > 0) begin
          ax -= xs[n-1]; ay -= ys[n-1];
          axy -= xs[n-1] * ys[n-1];
          axx -= xs[n-1] * xs[n-1];
          ayy -= ys[n-1] * ys[n-1];
          n--;
          c = classify(n, ax, ay, axy, axx, ayy);
        end
        r.stable_size = n[cspt_pkg::SIZE_W-1:0];
      end
      r.overflowed = dropped;
      expected_q.push_back(r);
      clear();
    endfunction

    function void check_result(cspt_pkg::out_t got);
      cspt_pkg::out_t e;
      results++;
      never_cnt += got.never_stable;
      ovf_cnt += got.overflowed;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.stable_size !== e.stable_size) begin
        $display("%0t: stable_size exp %0d got %0d", $time, e.stable_size, got.stable_size);
        errors++;
      end
      if (got.never_stable !== e.never_stable) begin
        $display("%0t: never_stable exp %0b got %0b", $time, e.never_stable,
                 got.never_stable);
        errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $display("%0t: overflowed exp %0b got %0b", $time, e.overflowed, got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  cspt_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  cspt_pkg::out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [cspt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [cspt_pkg::CORR_W-1:0] cfg_data = '0;

  stability_board sb = new();
  int gap_pct = 0;     // chance of a sender gap per cycle
  int stall_pct = 0;   // chance of receiver stall per cycle
  int idle_cnt = 0;
  int pairs_sent = 0;

  always #5 clk = ~clk;

  correlation_stability_point_core #(.MAX_SAMPLES(MAX_SAMPLES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // receiver: random back-pressure, check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_correlation_stability_point_core: errors");
      $finish;
    end
  end

  // one pair transfer; valid stays high into the next call unless a gap is drawn
  task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
    cspt_pkg::in_t d;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    d.x_sample = x;
    d.y_sample = y;
    d.last_pair = last;
    in_valid <= 1;
    in_data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pair(d);
    pairs_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 0;
    @(posedge clk);
  endtask

  // drain all expected results, then let any trailing work settle
  task automatic drain();
    stop_sending();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // one register transfer; the caller drops cfg_valid after the last one
  task automatic write_reg(cspt_pkg::cfg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_corridor(logic [15:0] lo, logic [15:0] hi, logic [15:0] floor_n);
    drain();
    write_reg(cspt_pkg::CFG_LOWER, lo);
    write_reg(cspt_pkg::CFG_UPPER, hi);
    write_reg(cspt_pkg::CFG_MIN, floor_n);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] clip(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // one sample of n pairs; mostly linear with noise, sometimes pure noise
  task automatic send_sample(int n);
    int slope, noise, span, mode, x, y;
    mode = $urandom_range(9);
    slope = $signed($urandom_range(16)) - 8;
    noise = $urandom_range(4000);
    span = (mode == 0) ? 32767 : $urandom_range(4000, 1);
    for (int i = 0; i < n; i++) begin
      x = $signed($urandom_range(2 * span)) - span;
      if (mode == 0) begin
        x = $signed($urandom_range(65535)) - 32768;
        y = $signed($urandom_range(65535)) - 32768;
      end else begin
        y = (x * slope) / 4 + $signed($urandom_range(2 * noise)) - noise;
      end
      if (mode == 1 && $urandom_range(1)) x = 5;  // flat stretches
      send_pair(clip(x), clip(y), i == n - 1);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part at reset corridor
    send_pair(16'sh7fff, 16'sh8000, 1);           // single pair, zero variance
    send_pair(16'sh8000, 16'sh8000, 0);
    send_pair(16'sh7fff, 16'sh7fff, 0);
    send_pair(16'sh0000, 16'sh0001, 1);           // near perfect positive: outside
    send_pair(16'sh8000, 16'sh7fff, 0);
    send_pair(16'sh7fff, 16'sh8000, 0);
    send_pair(16'sh0100, 16'sh0000, 1);           // negative correlation: outside
    send_pair(16'sh0003, 16'sh0007, 0);
    send_pair(16'sh0003, 16'sh8000, 1);           // constant x, zero variance

    // widest corridor, smallest floor: the walk may go down to one pair
    set_corridor(16'h8000, 16'h7fff, 16'd1);
    send_sample(12);
    for (int i = 0; i < 5; i++) send_pair(clip(i * 100), clip(i * 37 + (i % 2) * 900), i == 4);

    // empty corridor (lower above upper): everything with variance is outside
    set_corridor(16'h7fff, 16'h8000, 16'd1);
    send_sample(6);

    // full store with drops; top floor keeps the walk off
    set_corridor(16'h8000, 16'h7fff, 16'd1024);
    for (int i = 0; i < MAX_SAMPLES + 6; i++)
      send_pair(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                i == MAX_SAMPLES + 5);
    send_sample(3);                               // overflow flag cleared again

    // random phases: idle pattern x corridor setting
    for (int ph = 0; ph < 8; ph++) begin
      int lo, hi;
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 46; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 46; end
        default: begin gap_pct = 21; stall_pct = 21; end
      endcase
      lo = $signed($urandom_range(65535)) - 32768;
      hi = $signed($urandom_range(65535)) - 32768;
      if (ph % 3 != 0 && lo > hi) begin int t = lo; lo = hi; hi = t; end
      if (ph == 4) begin lo = -32768; hi = 32767; end
      set_corridor(16'(lo), 16'(hi), 16'($urandom_range(ph == 5 ? 1 : 30, 1)));
      while (pairs_sent < 110 * (ph + 1) + 1060) begin
        if (ph == 2 && $urandom_range(9) == 0) drain();  // sender waits for results
        send_sample($urandom_range(40, 1));
      end
    end

    drain();
    gap_pct = 0;
    stall_pct = 0;
    $display("covered %0d pairs, %0d results (%0d never stable, %0d overflowed)",
             pairs_sent, sb.results, sb.never_cnt, sb.ovf_cnt);
    $display("over eight idle/corridor phases including full-store drops");
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("tb_correlation_stability_point_core: clean");
    else
      $display("tb_correlation_stability_point_core: errors");
    $finish;
  end

endmodule

// ===== correlation_stability_point_core.f =====
rtl/cspt_pkg.sv
rtl/cspt_mul.sv
rtl/correlation_stability_point_core.sv
dv/tb_correlation_stability_point_core.sv
